[rtl/backpressure_flow_scheduler_top_defines.svh]
// assertion macros used by the scheduler sequencer
`ifndef BACKPRESSURE_FLOW_SCHEDULER_TOP_DEFINES_SVH
`define BACKPRESSURE_FLOW_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BFS_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfs: assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define BFS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfs: assertion failed");

`endif

[rtl/bfs_pkg.sv]
// types, constants and codes of the backpressure flow scheduler
package bfs_pkg;

   // sizing
   localparam int MAX_FLOWS         = 16;
   localparam int QUEUE_LENGTH_BITS = 12;
   localparam int IDX_BITS          = $clog2(MAX_FLOWS);
   localparam int CNT_BITS          = $clog2(MAX_FLOWS + 1);
   localparam int LEN_BITS          = QUEUE_LENGTH_BITS;
   localparam int BP_BITS           = LEN_BITS + 1;
   localparam int DIFF_BITS         = BP_BITS + 1;

   // fixed port field widths
   localparam int KIND_BITS      = 2;
   localparam int FLOW_BITS      = 4;
   localparam int FIELD_LEN_BITS = 12;
   localparam int OUT_BP_BITS    = 13;
   localparam int ACTIVE_BITS    = 5;
   localparam int DEST_BITS      = 12;
   localparam int SEED_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SEED_BITS-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [SEED_BITS-1:0] SEED_RESET = 16'd1;
   localparam logic [DEST_BITS-1:0] DEST_RESET = 12'd100;
   localparam int                   BP_SAT     = 4095;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_FLOWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIE_SEED     = 2'd2;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH     = 2'd0,
      KIND_NEIGHBOR = 2'd1,
      KIND_LOCAL    = 2'd2,
      KIND_SCHEDULE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] loc_len;
      logic [LEN_BITS-1:0] nbr_len;
      logic [BP_BITS-1:0]  bp;
   } entry_type;

   typedef struct packed {
      logic [DIFF_BITS-1:0] value;
      logic                 gt;
      logic                 eq;
   } diff_type;

   typedef struct packed {
      logic               grant_valid;
      logic [IDX_BITS-1:0] flow;
      logic [BP_BITS-1:0]  bp;
   } result_type;

   typedef struct packed {
      logic res_valid;
      logic tie_step;
   } seq_status_type;

endpackage

[rtl/backpressure_flow_scheduler_top.sv]
// top level of the backpressure flow scheduler
//
// usage:
//   req_* channel (valid/ready) carries one item: push, neighbor report, local length
//   update or schedule request. every item yields exactly one rsp_* item; only a
//   schedule request can carry rsp_grant_valid = 1, others return all zero.
//   csr_* channel writes active_flows (0), destination_neighbor_length (1) and
//   tie_seed (2); csr_ready is always high, a write to index 3 is dropped, and a
//   tie_seed write reloads the tie-break lfsr at once. write only while idle.
// operation:
//   push, report: the entry is rewritten in the update state with backpressure
//   from the shared subtractor; a local update keeps the old backpressure.
//   schedule: one table entry per cycle through the same subtractor, acting as a
//   comparator, over min(active_flows, 16) entries, then on to the output register.
//   req_ready is low while an item is being worked on.
// reset: tables clear to zero, registers return to 0 / 100 / 1, lfsr loads 1.
// stall: a result waits in the output register; the next item is accepted and
//   worked, then waits in the sequencer until the output register frees up.
module backpressure_flow_scheduler_top (
   input  logic                               clock,
   input  logic                               reset,
   // item input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bfs_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [bfs_pkg::FLOW_BITS-1:0]      req_flow_index,
   input  logic [bfs_pkg::FIELD_LEN_BITS-1:0] req_local_queue_length,
   input  logic [bfs_pkg::FIELD_LEN_BITS-1:0] req_neighbor_queue_length,
   input  logic                               req_next_hop_is_destination,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_grant_valid,
   output logic [bfs_pkg::FLOW_BITS-1:0]      rsp_granted_flow,
   output logic signed [bfs_pkg::OUT_BP_BITS-1:0] rsp_granted_backpressure,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bfs_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bfs_pkg::*;

   // configuration registers
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [DEST_BITS-1:0]   dest_ff, dest_in;
   logic [SEED_BITS-1:0]   lfsr_ff, lfsr_in;
   logic [SEED_BITS-1:0]   lfsr_next;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   grant_ff, grant_in;
   logic [FLOW_BITS-1:0]   flow_ff, flow_in;
   logic [OUT_BP_BITS-1:0] bp_ff, bp_in;

   logic                   csr_write;
   logic                   res_taken;
   logic [OUT_BP_BITS-1:0] bp_sat;

   logic                   tbl_wr_en;
   logic [IDX_BITS-1:0]    tbl_wr_idx;
   entry_type              tbl_wr_entry;
   logic [IDX_BITS-1:0]    tbl_rd_idx;
   entry_type              tbl_rd_entry;
   logic [DIFF_BITS-1:0]   diff_a;
   logic [DIFF_BITS-1:0]   diff_b;
   diff_type               diff_res;
   seq_status_type         status;
   result_type             result;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // galois lfsr, right shift; the drawn tie bit is bit 0 of the advanced value
   assign lfsr_next = {1'b0, lfsr_ff[SEED_BITS-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   always_comb begin
      active_in = active_ff;
      dest_in   = dest_ff;
      lfsr_in   = status.tie_step ? lfsr_next : lfsr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_FLOWS: active_in = csr_data[ACTIVE_BITS-1:0];
            CSR_DEST_LENGTH:  dest_in   = csr_data[DEST_BITS-1:0];
            CSR_TIE_SEED:     lfsr_in   = csr_data[SEED_BITS-1:0];
            default:          active_in = active_ff;
         endcase
      end
   end

   // saturate the granted backpressure to the output range
   always_comb begin
      if (int'($signed(result.bp)) > BP_SAT) begin
         bp_sat = OUT_BP_BITS'(BP_SAT);
      end else if (int'($signed(result.bp)) < -BP_SAT) begin
         bp_sat = OUT_BP_BITS'(-BP_SAT);
      end else begin
         bp_sat = OUT_BP_BITS'($signed(result.bp));
      end
   end

   // output register loads when empty or being drained
   assign res_taken = status.res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      grant_in     = grant_ff;
      flow_in      = flow_ff;
      bp_in        = bp_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         grant_in     = result.grant_valid;
         flow_in      = FLOW_BITS'(result.flow);
         bp_in        = bp_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         dest_ff      <= DEST_RESET;
         lfsr_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         dest_ff      <= dest_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grant_ff <= grant_in;
      flow_ff  <= flow_in;
      bp_ff    <= bp_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_grant_valid          = grant_ff;
   assign rsp_granted_flow         = flow_ff;
   assign rsp_granted_backpressure = bp_ff;

   bfs_flow_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_idx   (tbl_wr_idx),
      .wr_entry (tbl_wr_entry),
      .rd_idx   (tbl_rd_idx),
      .rd_entry (tbl_rd_entry)
   );

   // one subtractor serves both the backpressure recompute and the walk compare
   bfs_diff_unit u_diff (
      .op_a (diff_a),
      .op_b (diff_b),
      .res  (diff_res)
   );

   bfs_sequencer u_seq (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_kind                    (req_kind),
      .req_flow_index              (req_flow_index),
      .req_local_queue_length      (req_local_queue_length),
      .req_neighbor_queue_length   (req_neighbor_queue_length),
      .req_next_hop_is_destination (req_next_hop_is_destination),
      .active_flows                (active_ff),
      .dest_length                 (dest_ff),
      .tbl_wr_en                   (tbl_wr_en),
      .tbl_wr_idx                  (tbl_wr_idx),
      .tbl_wr_entry                (tbl_wr_entry),
      .tbl_rd_idx                  (tbl_rd_idx),
      .tbl_rd_entry                (tbl_rd_entry),
      .diff_a                      (diff_a),
      .diff_b                      (diff_b),
      .diff_res                    (diff_res),
      .tie_bit                     (lfsr_next[0]),
      .res_taken                   (res_taken),
      .status                      (status),
      .result                      (result)
   );

endmodule

[rtl/bfs_flow_table.sv]
// per-flow table of local length, neighbor length and backpressure
module bfs_flow_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [bfs_pkg::IDX_BITS-1:0] wr_idx,
   input  bfs_pkg::entry_type           wr_entry,
   input  logic [bfs_pkg::IDX_BITS-1:0] rd_idx,
   output bfs_pkg::entry_type           rd_entry
);
   import bfs_pkg::*;

   entry_type entries_ff [MAX_FLOWS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FLOWS; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entries_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = entries_ff[rd_idx];

endmodule

[rtl/bfs_diff_unit.sv]
// shared signed subtract and compare unit
module bfs_diff_unit (
   input  logic [bfs_pkg::DIFF_BITS-1:0] op_a,
   input  logic [bfs_pkg::DIFF_BITS-1:0] op_b,
   output bfs_pkg::diff_type             res
);
   import bfs_pkg::*;

   logic [DIFF_BITS-1:0] value;

   assign value     = op_a - op_b;
   assign res.value = value;
   assign res.eq    = (value == '0);
   // positive difference: sign clear and not zero
   assign res.gt    = !value[DIFF_BITS-1] && (value != '0);

endmodule

[rtl/bfs_sequencer.sv]
// sequencer for table updates and the schedule walk
`include "backpressure_flow_scheduler_top_defines.svh"

module bfs_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bfs_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [bfs_pkg::FLOW_BITS-1:0]      req_flow_index,
   input  logic [bfs_pkg::FIELD_LEN_BITS-1:0] req_local_queue_length,
   input  logic [bfs_pkg::FIELD_LEN_BITS-1:0] req_neighbor_queue_length,
   input  logic                               req_next_hop_is_destination,
   input  logic [bfs_pkg::ACTIVE_BITS-1:0]    active_flows,
   input  logic [bfs_pkg::DEST_BITS-1:0]      dest_length,
   output logic                               tbl_wr_en,
   output logic [bfs_pkg::IDX_BITS-1:0]       tbl_wr_idx,
   output bfs_pkg::entry_type                 tbl_wr_entry,
   output logic [bfs_pkg::IDX_BITS-1:0]       tbl_rd_idx,
   input  bfs_pkg::entry_type                 tbl_rd_entry,
   output logic [bfs_pkg::DIFF_BITS-1:0]      diff_a,
   output logic [bfs_pkg::DIFF_BITS-1:0]      diff_b,
   input  bfs_pkg::diff_type                  diff_res,
   input  logic                               tie_bit,
   input  logic                               res_taken,
   output bfs_pkg::seq_status_type            status,
   output bfs_pkg::result_type                result
);
   import bfs_pkg::*;

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [FLOW_BITS-1:0] flow_ff, flow_in;
   logic [LEN_BITS-1:0]  loc_ff, loc_in;
   logic [LEN_BITS-1:0]  nbr_ff, nbr_in;
   logic                 to_dest_ff, to_dest_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic                 best_valid_ff, best_valid_in;
   logic [IDX_BITS-1:0]  best_flow_ff, best_flow_in;
   logic [BP_BITS-1:0]   best_bp_ff, best_bp_in;

   logic                 accept;
   logic                 in_range;
   logic [CNT_BITS-1:0]  req_limit;
   logic [CNT_BITS-1:0]  idx_next;
   logic                 walk_last;
   logic                 occupied;
   logic [LEN_BITS-1:0]  new_loc;
   logic [LEN_BITS-1:0]  new_nbr;

   assign accept    = req_valid && req_ready;
   assign in_range  = int'(req_flow_index) < MAX_FLOWS;
   assign req_limit = (int'(active_flows) > MAX_FLOWS) ? CNT_BITS'(MAX_FLOWS)
                                                       : CNT_BITS'(active_flows);
   assign idx_next  = idx_ff + 1'b1;
   assign walk_last = (idx_next == limit_ff);
   assign occupied  = (tbl_rd_entry.loc_len != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == KIND_SCHEDULE) begin
                  state_in = (req_limit == '0) ? S_DONE : S_WALK;
               end else begin
                  state_in = in_range ? S_UPDATE : S_DONE;
               end
            end
         end
         S_UPDATE: state_in = S_DONE;
         S_WALK: begin
            if (walk_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      status.res_valid = 1'b0;
      status.tie_step  = 1'b0;
      tbl_wr_en        = 1'b0;
      tbl_rd_idx       = IDX_BITS'(flow_ff);
      case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_UPDATE: tbl_wr_en = 1'b1;
         S_WALK: begin
            tbl_rd_idx      = idx_ff[IDX_BITS-1:0];
            status.tie_step = occupied && best_valid_ff && !diff_res.gt && diff_res.eq;
         end
         S_DONE:   status.res_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // update entry: new lengths, backpressure from the shared unit (kept for a local update)
   always_comb begin
      new_loc = (kind_ff == KIND_NEIGHBOR) ? tbl_rd_entry.loc_len : loc_ff;
      case (kind_ff)
         KIND_PUSH:     new_nbr = to_dest_ff ? LEN_BITS'(dest_length) : tbl_rd_entry.nbr_len;
         KIND_NEIGHBOR: new_nbr = nbr_ff;
         default:       new_nbr = tbl_rd_entry.nbr_len;
      endcase
      tbl_wr_idx           = IDX_BITS'(flow_ff);
      tbl_wr_entry.loc_len = new_loc;
      tbl_wr_entry.nbr_len = new_nbr;
      tbl_wr_entry.bp      = (kind_ff == KIND_LOCAL) ? tbl_rd_entry.bp
                                                     : diff_res.value[BP_BITS-1:0];
   end

   // shared unit operands: recompute during update, compare during walk
   always_comb begin
      if (state_ff == S_WALK) begin
         diff_a = {tbl_rd_entry.bp[BP_BITS-1], tbl_rd_entry.bp};
         diff_b = {best_bp_ff[BP_BITS-1], best_bp_ff};
      end else begin
         diff_a = {2'b00, new_loc};
         diff_b = {2'b00, new_nbr};
      end
   end

   // datapath
   always_comb begin
      kind_in       = kind_ff;
      flow_in       = flow_ff;
      loc_in        = loc_ff;
      nbr_in        = nbr_ff;
      to_dest_in    = to_dest_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      best_valid_in = best_valid_ff;
      best_flow_in  = best_flow_ff;
      best_bp_in    = best_bp_ff;
      if (accept) begin
         kind_in       = kind_type'(req_kind);
         flow_in       = req_flow_index;
         loc_in        = LEN_BITS'(req_local_queue_length);
         nbr_in        = LEN_BITS'(req_neighbor_queue_length);
         to_dest_in    = req_next_hop_is_destination;
         idx_in        = '0;
         limit_in      = req_limit;
         best_valid_in = 1'b0;
         best_flow_in  = '0;
         best_bp_in    = '0;
      end else if (state_ff == S_WALK) begin
         idx_in = idx_next;
         if (occupied) begin
            if (!best_valid_ff || diff_res.gt) begin
               best_valid_in = 1'b1;
               best_flow_in  = idx_ff[IDX_BITS-1:0];
               best_bp_in    = tbl_rd_entry.bp;
            end else if (diff_res.eq && tie_bit) begin
               best_flow_in = idx_ff[IDX_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         best_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      flow_ff      <= flow_in;
      loc_ff       <= loc_in;
      nbr_ff       <= nbr_in;
      to_dest_ff   <= to_dest_in;
      idx_ff       <= idx_in;
      limit_ff     <= limit_in;
      best_flow_ff <= best_flow_in;
      best_bp_ff   <= best_bp_in;
   end

   assign result.grant_valid = best_valid_ff;
   assign result.flow        = best_flow_ff;
   assign result.bp          = best_bp_ff;

   `BFS_ASSERT_NOW(walk_idx_below_limit, state_ff == S_WALK, idx_ff < limit_ff)
   `BFS_ASSERT_NOW(update_flow_in_range, state_ff == S_UPDATE, int'(flow_ff) < MAX_FLOWS)
   `BFS_ASSERT_NOW(tie_only_after_grant, status.tie_step, best_valid_ff && occupied)
   `BFS_ASSERT_NEXT(result_held_until_taken, state_ff == S_DONE && !res_taken,
                    state_ff == S_DONE && $stable(best_flow_ff) && $stable(best_bp_ff))

endmodule
